### design/polygon_vertex_offset_unit_defines.svh
// assertion macros for the polygon vertex offset unit
`ifndef POLYGON_VERTEX_OFFSET_UNIT_DEFINES_SVH
`define POLYGON_VERTEX_OFFSET_UNIT_DEFINES_SVH

// same-cycle implication
`define PVO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("result beat check failed");

// next-cycle implication
`define PVO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("result channel check failed");

`endif

### design/pvo_pkg.sv
`timescale 1ns / 1ps
package pvo_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned OFFS_W    = 27;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [IDX_W-1:0] MAX_VERTICES = 16'd65535;

  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 35;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned VEC_W  = 34;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned UV_W   = 18;
  localparam int unsigned COS_W  = 36;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DISP_W = 41;
  localparam int unsigned SUM_W  = 43;
  localparam int unsigned NORM_TOP = 30;

  localparam longint unsigned COS_THR_L = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
  localparam logic signed [COS_W-1:0] COS_THR = COS_W'(COS_THR_L);
  localparam logic [DISP_W-1:0] DISP_CAP = {1'b1, {(DISP_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_OVFL  = 2'd2
  } status_e;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    CRN_PREV,
    CRN_CUR,
    CRN_WRAP
  } corner_e;

  typedef enum logic [1:0] {
    UV_IN,
    UV_OUT,
    UV_NRM
  } uv_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_MAG,
    S_NORM,
    S_SQX,
    S_SQY,
    S_SQRT_GO,
    S_SQRT_WT,
    S_DIVX_GO,
    S_DIVX_WT,
    S_DIVY_GO,
    S_DIVY_WT,
    S_UV_ST,
    S_COS_A,
    S_COS_B,
    S_COS_C,
    S_DMUL,
    S_DSEL,
    S_DWT,
    S_DADD,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } iter_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic [REM_W-1:0]  rem;
  } iter_rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

endpackage

### design/pvo_vtx_if.sv
`timescale 1ns / 1ps
interface pvo_vtx_if import pvo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      final_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, final_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, final_vertex, output ready);
endinterface

### design/pvo_res_if.sv
`timescale 1ns / 1ps
interface pvo_res_if import pvo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [IDX_W-1:0]          vertex_index;
  status_e                   status;
  logic                      last_result;

  modport source (output valid, out_x, out_y, out_z, vertex_index, status, last_result,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, vertex_index, status, last_result,
                  output ready);
endinterface

### design/polygon_vertex_offset_unit.sv
`timescale 1ns / 1ps
// Miter offset of one closed polygon, vertices streamed in order with the last one flagged.
// Vertex k-1 leaves when vertex k arrives; the final vertex gives three beats (vertex n-2,
// vertex n-1, then vertex 0 with last_result set). Fewer than three vertices, or more than
// 65535, end in a single error beat. The input is not ready while a vertex is being worked
// on; the first two vertices of a polygon and any dropped vertex are only stored or dropped,
// so the input stays ready. Each corner uses one shared bit-serial unit, which does every
// square root (32 steps) and every divide (64 steps) in turn: up to three roots and up to
// eight divides a corner. Each unit vector also takes up to 30 one-bit normalising shifts.
// The output register lets a new vertex be taken while the last beat still waits.
module polygon_vertex_offset_unit import pvo_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic signed [OFFS_W-1:0] cfg_wdata_i,
  pvo_vtx_if.sink                  vtx_i,
  pvo_res_if.source                res_o
);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

  state_e state_q, state_d;

  logic signed [OFFS_W-1:0] off_q;
  logic [IDX_W-1:0]         count_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     fin_q;
  vtx_t                     cur_q, first_q, second_q, older_q, newer_q;
  corner_e                  corner_q;
  uv_e                      uv_sel_q;
  logic                     axis_q;
  status_e                  err_q;

  logic signed [VEC_W-1:0]  vx_q, vy_q;
  logic [MAG_W-1:0]         mx_q, my_q;
  logic [LEN_W-1:0]         len_q;
  logic signed [UV_W-1:0]   uvx_q, uvy_q;
  logic signed [UV_W-1:0]   ax_q, ay_q, bx_q, by_q, nx_q, ny_q;
  logic signed [PROD_W-1:0] prod_q, cos_acc_q;
  logic [PROD_W-1:0]        sq_acc_q;
  logic signed [COS_W-1:0]  cos_q;
  logic                     neg_q;
  logic [DISP_W-1:0]        m_q;
  logic signed [COORD_W-1:0] rx_q, ry_q;

  logic                      ov_q;
  logic signed [COORD_W-1:0] o_x_q, o_y_q, o_z_q;
  logic [IDX_W-1:0]          o_idx_q;
  status_e                   o_stat_q;
  logic                      o_last_q;

  iter_req_t req;
  iter_rsp_t rsp;

  vtx_t                     pv, cv, nv;
  logic signed [VEC_W-1:0]  ld_x, ld_y;
  logic [MAG_W-1:0]         mag_x, mag_y, mmax;
  logic signed [VEC_W-1:0]  mul_a, mul_b;
  logic signed [2*VEC_W-1:0] mul_p;
  logic signed [UV_W-1:0]   n_ax;
  logic [UV_W-2:0]          mag_n;
  logic [OFFS_W-1:0]        mag_off;
  logic signed [UV_W-1:0]   q_sgn;
  logic                     div_cap, div_rnd;
  logic signed [COORD_W-1:0] base;
  logic signed [SUM_W-1:0]  mvec, dsum;
  logic signed [COORD_W-1:0] sat_v;
  logic                     acc, cnt_full, fin_in, slot_free, last_crn, emit_done, shift_win;
  logic [IDX_W-1:0]         crn_idx;

  pvo_iter u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign vtx_i.ready = (state_q == S_IDLE);
  assign acc         = vtx_i.valid && (state_q == S_IDLE);
  assign fin_in      = vtx_i.final_vertex;
  assign cnt_full    = (count_q == MAX_VERTICES);
  assign slot_free   = !ov_q || res_o.ready;
  assign last_crn    = fin_q ? (corner_q == CRN_WRAP) : (corner_q == CRN_PREV);
  assign emit_done   = (state_q == S_EMIT) && slot_free && last_crn;
  assign shift_win   = (acc && !fin_in && !cnt_full && (count_q < IDX_W'(2)))
                       || (emit_done && !fin_q);

  always_comb begin
    unique case (corner_q)
      CRN_PREV: begin
        pv = older_q; cv = newer_q; nv = cur_q; crn_idx = idx_q - 1'b1;
      end
      CRN_CUR: begin
        pv = newer_q; cv = cur_q; nv = first_q; crn_idx = idx_q;
      end
      CRN_WRAP: begin
        pv = cur_q; cv = first_q; nv = second_q; crn_idx = '0;
      end
      default: begin
        pv = older_q; cv = newer_q; nv = cur_q; crn_idx = '0;
      end
    endcase
  end

  always_comb begin
    unique case (uv_sel_q)
      UV_IN: begin
        ld_x = VEC_W'(cv.x) - VEC_W'(pv.x);
        ld_y = VEC_W'(cv.y) - VEC_W'(pv.y);
      end
      UV_OUT: begin
        ld_x = VEC_W'(nv.x) - VEC_W'(cv.x);
        ld_y = VEC_W'(nv.y) - VEC_W'(cv.y);
      end
      default: begin
        ld_x = -VEC_W'(ay_q) - VEC_W'(by_q);
        ld_y = VEC_W'(ax_q) + VEC_W'(bx_q);
      end
    endcase
  end

  assign mag_x = vx_q[VEC_W-1] ? MAG_W'(-vx_q) : MAG_W'(vx_q);
  assign mag_y = vy_q[VEC_W-1] ? MAG_W'(-vy_q) : MAG_W'(vy_q);
  assign mmax  = (mx_q > my_q) ? mx_q : my_q;

  assign n_ax    = axis_q ? ny_q : nx_q;
  assign mag_n   = n_ax[UV_W-1] ? (UV_W-1)'(-n_ax) : (UV_W-1)'(n_ax);
  assign mag_off = off_q[OFFS_W-1] ? OFFS_W'(-off_q) : OFFS_W'(off_q);

  always_comb begin
    unique case (state_q)
      S_SQX: begin
        mul_a = $signed({1'b0, mx_q});
        mul_b = $signed({1'b0, mx_q});
      end
      S_SQY: begin
        mul_a = $signed({1'b0, my_q});
        mul_b = $signed({1'b0, my_q});
      end
      S_COS_A: begin
        mul_a = -VEC_W'(ay_q);
        mul_b = VEC_W'(nx_q);
      end
      S_COS_B: begin
        mul_a = VEC_W'(ax_q);
        mul_b = VEC_W'(ny_q);
      end
      default: begin
        mul_a = $signed({{(VEC_W-UV_W+1){1'b0}}, mag_n});
        mul_b = $signed({{(VEC_W-OFFS_W){1'b0}}, mag_off});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.num   = '0;
    req.den   = '0;
    unique case (state_q)
      S_SQRT_GO: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        req.num   = sq_acc_q + prod_q;
      end
      S_DIVX_GO: begin
        req.start = 1'b1;
        req.num   = (NUM_W'(mx_q) << FRAC_BITS) + NUM_W'(len_q >> 1);
        req.den   = DEN_W'(len_q);
      end
      S_DIVY_GO: begin
        req.start = 1'b1;
        req.num   = (NUM_W'(my_q) << FRAC_BITS) + NUM_W'(len_q >> 1);
        req.den   = DEN_W'(len_q);
      end
      S_DSEL: begin
        req.start = (cos_q > COS_THR);
        req.num   = prod_q << FRAC_BITS;
        req.den   = cos_q[DEN_W-1:0];
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  assign div_cap = |rsp.quot[NUM_W-1:DISP_W-1];
  assign div_rnd = {rsp.rem, 1'b0} >= (REM_W+1)'(cos_q[DEN_W-1:0]);

  always_comb begin
    q_sgn = $signed({1'b0, rsp.quot[UV_W-2:0]});
    if ((state_q == S_DIVX_WT) ? vx_q[VEC_W-1] : vy_q[VEC_W-1]) begin
      q_sgn = -q_sgn;
    end
  end

  always_comb begin
    base  = axis_q ? cv.y : cv.x;
    mvec  = $signed({{(SUM_W-DISP_W){1'b0}}, m_q});
    dsum  = SUM_W'(base) + (neg_q ? -mvec : mvec);
    if (dsum > SAT_MAX) begin
      sat_v = COORD_W'(SAT_MAX);
    end else if (dsum < SAT_MIN) begin
      sat_v = COORD_W'(SAT_MIN);
    end else begin
      sat_v = COORD_W'(dsum);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (cnt_full) begin
            state_d = fin_in ? S_ERR : S_IDLE;
          end else if (count_q < IDX_W'(2)) begin
            state_d = fin_in ? S_ERR : S_IDLE;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD:    state_d = S_MAG;
      S_MAG:     state_d = ((vx_q == '0) && (vy_q == '0)) ? S_UV_ST : S_NORM;
      S_NORM: begin
        if (!(mmax[MAG_W-1:NORM_TOP+1] != '0) && mmax[NORM_TOP]) begin
          state_d = S_SQX;
        end
      end
      S_SQX:     state_d = S_SQY;
      S_SQY:     state_d = S_SQRT_GO;
      S_SQRT_GO: state_d = S_SQRT_WT;
      S_SQRT_WT: if (rsp.done) state_d = S_DIVX_GO;
      S_DIVX_GO: state_d = S_DIVX_WT;
      S_DIVX_WT: if (rsp.done) state_d = S_DIVY_GO;
      S_DIVY_GO: state_d = S_DIVY_WT;
      S_DIVY_WT: if (rsp.done) state_d = S_UV_ST;
      S_UV_ST:   state_d = (uv_sel_q == UV_NRM) ? S_COS_A : S_LOAD;
      S_COS_A:   state_d = S_COS_B;
      S_COS_B:   state_d = S_COS_C;
      S_COS_C:   state_d = S_DMUL;
      S_DMUL:    state_d = S_DSEL;
      S_DSEL:    state_d = (cos_q > COS_THR) ? S_DWT : S_DADD;
      S_DWT:     if (rsp.done) state_d = S_DADD;
      S_DADD:    state_d = axis_q ? S_EMIT : S_DMUL;
      S_EMIT: begin
        if (slot_free) begin
          state_d = last_crn ? S_IDLE : S_LOAD;
        end
      end
      S_ERR:     if (slot_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      off_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      if (acc) begin
        if (fin_in) begin
          count_q <= '0;
        end else if (!cnt_full) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (((state_q == S_EMIT) || (state_q == S_ERR)) && slot_free) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // window and first two vertices
  always_ff @(posedge clk_i) begin
    if (acc && !fin_in && !cnt_full && (count_q == '0)) begin
      first_q <= '{x: vtx_i.pos_x, y: vtx_i.pos_y, z: vtx_i.pos_z};
    end
    if (acc && !fin_in && !cnt_full && (count_q == IDX_W'(1))) begin
      second_q <= '{x: vtx_i.pos_x, y: vtx_i.pos_y, z: vtx_i.pos_z};
    end
    if (shift_win) begin
      older_q <= newer_q;
      newer_q <= acc ? '{x: vtx_i.pos_x, y: vtx_i.pos_y, z: vtx_i.pos_z} : cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cur_q    <= '{x: vtx_i.pos_x, y: vtx_i.pos_y, z: vtx_i.pos_z};
          fin_q    <= fin_in;
          idx_q    <= count_q;
          corner_q <= CRN_PREV;
          uv_sel_q <= UV_IN;
          axis_q   <= 1'b0;
          err_q    <= cnt_full ? STAT_OVFL : STAT_SHORT;
        end
      end
      S_LOAD: begin
        vx_q <= ld_x;
        vy_q <= ld_y;
      end
      S_MAG: begin
        mx_q  <= mag_x;
        my_q  <= mag_y;
        uvx_q <= '0;
        uvy_q <= '0;
      end
      S_NORM: begin
        if (mmax[MAG_W-1:NORM_TOP+1] != '0) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else if (!mmax[NORM_TOP]) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end
      end
      S_SQX: prod_q <= mul_p[PROD_W-1:0];
      S_SQY: begin
        sq_acc_q <= prod_q;
        prod_q   <= mul_p[PROD_W-1:0];
      end
      S_SQRT_WT: if (rsp.done) len_q <= rsp.quot[LEN_W-1:0];
      S_DIVX_WT: if (rsp.done) uvx_q <= q_sgn;
      S_DIVY_WT: if (rsp.done) uvy_q <= q_sgn;
      S_UV_ST: begin
        unique case (uv_sel_q)
          UV_IN: begin
            ax_q <= uvx_q; ay_q <= uvy_q; uv_sel_q <= UV_OUT;
          end
          UV_OUT: begin
            bx_q <= uvx_q; by_q <= uvy_q; uv_sel_q <= UV_NRM;
          end
          default: begin
            nx_q <= uvx_q; ny_q <= uvy_q;
          end
        endcase
      end
      S_COS_A: prod_q <= mul_p[PROD_W-1:0];
      S_COS_B: begin
        cos_acc_q <= prod_q;
        prod_q    <= mul_p[PROD_W-1:0];
      end
      S_COS_C: cos_q <= COS_W'(cos_acc_q + prod_q);
      S_DMUL: begin
        prod_q <= mul_p[PROD_W-1:0];
        neg_q  <= n_ax[UV_W-1] ^ off_q[OFFS_W-1];
      end
      S_DSEL: begin
        m_q <= DISP_W'((prod_q + HALF_LSB) >> FRAC_BITS);
      end
      S_DWT: begin
        if (rsp.done) begin
          m_q <= div_cap ? DISP_CAP : rsp.quot[DISP_W-1:0] + DISP_W'(div_rnd);
        end
      end
      S_DADD: begin
        if (axis_q) begin
          ry_q <= sat_v;
        end else begin
          rx_q   <= sat_v;
          axis_q <= 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          o_x_q    <= rx_q;
          o_y_q    <= ry_q;
          o_z_q    <= cv.z;
          o_idx_q  <= crn_idx;
          o_stat_q <= STAT_OK;
          o_last_q <= (corner_q == CRN_WRAP);
          corner_q <= (corner_q == CRN_PREV) ? CRN_CUR : CRN_WRAP;
          uv_sel_q <= UV_IN;
          axis_q   <= 1'b0;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          o_x_q    <= '0;
          o_y_q    <= '0;
          o_z_q    <= '0;
          o_idx_q  <= '0;
          o_stat_q <= err_q;
          o_last_q <= 1'b1;
        end
      end
      default: begin
        axis_q <= axis_q;
      end
    endcase
  end

  assign res_o.valid        = ov_q;
  assign res_o.out_x        = o_x_q;
  assign res_o.out_y        = o_y_q;
  assign res_o.out_z        = o_z_q;
  assign res_o.vertex_index = o_idx_q;
  assign res_o.status       = o_stat_q;
  assign res_o.last_result  = o_last_q;

endmodule

### design/pvo_iter.sv
`timescale 1ns / 1ps
module pvo_iter import pvo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iter_req_t req_i,
  output iter_rsp_t rsp_o
);

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(NUM_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  op_e              op_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] quot_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [NUM_W-1:0] num_nx;
  logic             take;

  always_comb begin
    unique case (op_q)
      OP_SQRT: begin
        rem_sh = {rem_q[REM_W-3:0], num_q[NUM_W-1:NUM_W-2]};
        trial  = {quot_q[REM_W-3:0], 2'b01};
        num_nx = {num_q[NUM_W-3:0], 2'b00};
      end
      default: begin
        rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
        trial  = {1'b0, den_q};
        num_nx = {num_q[NUM_W-2:0], 1'b0};
      end
    endcase
    take = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == OP_SQRT) ? SQRT_LAST : DIV_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_nx;
      rem_q  <= take ? rem_sh - trial : rem_sh;
      quot_q <= {quot_q[NUM_W-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

### design/pvo_chk.sv
`timescale 1ns / 1ps
`include "polygon_vertex_offset_unit_defines.svh"
module pvo_chk import pvo_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic signed [COORD_W-1:0] res_x_i,
  input logic signed [COORD_W-1:0] res_y_i,
  input logic [IDX_W-1:0]          res_idx_i,
  input status_e                   res_status_i,
  input logic                      res_last_i
);

  logic err_beat;
  logic ok_last;

  assign err_beat = res_valid_i && (res_status_i != STAT_OK);
  assign ok_last  = res_valid_i && res_last_i && (res_status_i == STAT_OK);

  // a waiting beat stays offered
  `PVO_ASSERT_NEXT(a_hold, res_valid_i && !res_ready_i, res_valid_i)

  // error beats close the polygon
  `PVO_ASSERT_NOW(a_err_last, err_beat, res_last_i)

  // error beats carry no vertex
  `PVO_ASSERT_NOW(a_err_zero, err_beat, {res_x_i, res_y_i, res_idx_i} == '0)

  // a good polygon closes on vertex 0
  `PVO_ASSERT_NOW(a_wrap_idx, ok_last, res_idx_i == '0)

endmodule

bind polygon_vertex_offset_unit pvo_chk u_pvo_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_x_i     (res_o.out_x),
  .res_y_i     (res_o.out_y),
  .res_idx_i   (res_o.vertex_index),
  .res_status_i(res_o.status),
  .res_last_i  (res_o.last_result)
);
